[src/dwa_pkg.sv]
// dwa_pkg: shared codes, reset values, flag layout and control types of the
// table-driven word acceptor
// no dependencies
`timescale 1ns / 1ps

package dwa_pkg;

    // default sizes of the automaton
    localparam int NUM_STATES_DEF  = 64;
    localparam int MAX_SYMBOLS_DEF = 32;

    // widths used to range-check port values against the parameters
    localparam int STATE_EXT_W = 11;
    localparam int SYM_EXT_W   = 9;

    // item functions
    localparam logic [2:0] FUNC_WRITE = 3'd0;
    localparam logic [2:0] FUNC_MARK  = 3'd1;
    localparam logic [2:0] FUNC_LIVE  = 3'd2;
    localparam logic [2:0] FUNC_CHAR  = 3'd3;
    localparam logic [2:0] FUNC_END   = 3'd4;

    // configuration registers
    localparam int         CFG_IDX_W         = 1;
    localparam logic [0:0] REG_INITIAL_STATE = 1'd0;
    localparam logic [0:0] REG_ALPHABET_SIZE = 1'd1;
    localparam logic [5:0] INITIAL_STATE_RST = 6'd0;
    localparam logic [5:0] ALPHABET_SIZE_RST = 6'd26;

    // symbol 0 is the byte 'a'
    localparam logic [7:0] FIRST_CHAR = 8'd97;

    // per-state flag word
    localparam int FLAG_W         = 2;
    localparam int FLAG_FINAL_BIT = 1;
    localparam int FLAG_LIVE_BIT  = 0;

    // live-state sequencer states
    typedef enum logic [3:0] {
        LS_CLEAR,
        LS_IDLE,
        LS_COPY_RD,
        LS_COPY_WR,
        LS_SCAN_RD,
        LS_SCAN_CHK,
        LS_SYM_RD,
        LS_SYM_TGT,
        LS_SYM_CHK,
        LS_NEXT
    } live_state_t;

    typedef struct packed {
        logic       start;
        logic [5:0] alphabet_size;
    } seq_ctrl_t;

    typedef struct packed {
        logic busy;
        logic clearing;
    } seq_stat_t;

endpackage

[src/dfa_word_acceptor.sv]
// dfa_word_acceptor: table-driven automaton, one character item per cycle when not stalled,
// end-word result registered after its flag read, items held off during that read
// live-state computation walks the table: copies final to live for every state, then checks
// each symbol of each state in passes until nothing changes; items are held off meanwhile
// reset: clears all NUM_STATES * 2**clog2(MAX_SYMBOLS) table entries (2048 by default)
// depends on dwa_pkg, dwa_ram, dwa_live_seq
`timescale 1ns / 1ps

module dfa_word_acceptor #(
    parameter int NUM_STATES  = dwa_pkg::NUM_STATES_DEF,
    parameter int MAX_SYMBOLS = dwa_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration writes
    input  logic                          cfg_we,
    input  logic [dwa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [5:0]                    cfg_data,
    // item channel
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [2:0]                    func,
    input  logic [5:0]                    from_state,
    input  logic [4:0]                    symbol_index,
    input  logic [5:0]                    to_state,
    input  logic [7:0]                    char_code,
    // result channel
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          accepted,
    output logic                          is_prefix
);

    localparam int SW     = $clog2(NUM_STATES);
    localparam int SYW    = $clog2(MAX_SYMBOLS);
    localparam int TAW    = SW + SYW;
    localparam int TDEPTH = NUM_STATES * (1 << SYW);
    localparam int TW     = SW + 1;   // valid bit over target state
    localparam int XW     = dwa_pkg::STATE_EXT_W;
    localparam int YW     = dwa_pkg::SYM_EXT_W;

    // configuration registers
    logic [5:0] initial_state_reg, initial_state_next;
    logic [5:0] alphabet_size_reg, alphabet_size_next;

    // run state: pend_reg marks a table lookup issued last cycle whose
    // answer is resolved from the ram output this cycle
    logic [SW-1:0] run_state_reg, run_state_next;
    logic          run_dead_reg, run_dead_next;
    logic          pend_reg, pend_next;

    // end word waits for its flag read
    logic          end_pend_reg, end_pend_next;
    logic          end_ok_reg, end_ok_next;

    // result register
    logic          result_valid_reg, result_valid_next;
    logic          accepted_reg, accepted_next;
    logic          is_prefix_reg, is_prefix_next;

    // memory ports
    logic               tbl_we;
    logic [TAW-1:0]     tbl_waddr;
    logic [TW-1:0]      tbl_wdata;
    logic [TAW-1:0]     tbl_raddr;
    logic [TW-1:0]      tbl_rdata;
    logic                        flg_we;
    logic [SW-1:0]               flg_waddr;
    logic [dwa_pkg::FLAG_W-1:0]  flg_wdata;
    logic [SW-1:0]               flg_raddr;
    logic [dwa_pkg::FLAG_W-1:0]  flg_rdata;

    // sequencer side
    dwa_pkg::seq_ctrl_t          seq_ctl;
    dwa_pkg::seq_stat_t          seq_stat;
    logic                        seq_tbl_we;
    logic [TAW-1:0]              seq_tbl_waddr;
    logic [TW-1:0]               seq_tbl_wdata;
    logic [TAW-1:0]              seq_tbl_raddr;
    logic                        seq_flg_we;
    logic [SW-1:0]               seq_flg_waddr;
    logic [dwa_pkg::FLAG_W-1:0]  seq_flg_wdata;
    logic [SW-1:0]               seq_flg_raddr;

    // decoded item
    logic          item_acc;
    logic          is_write, is_mark, is_live, is_char, is_end;
    logic [XW-1:0] from_ext, to_ext, init_ext;
    logic [YW-1:0] wsym_ext, csym_ext;
    logic [7:0]    csym;
    logic          from_ok, to_ok, wsym_ok, char_ok, init_ok;

    // resolved run state for this cycle
    logic          hit;
    logic [SW-1:0] res_state;
    logic          res_dead;

    //--------------------------------------------------------------------
    // configuration
    //--------------------------------------------------------------------
    always_comb
    begin
        initial_state_next = initial_state_reg;
        alphabet_size_next = alphabet_size_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                dwa_pkg::REG_INITIAL_STATE: initial_state_next = cfg_data;
                dwa_pkg::REG_ALPHABET_SIZE: alphabet_size_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    //--------------------------------------------------------------------
    // item decode and range checks
    //--------------------------------------------------------------------
    // items are held off while the sequencer owns the memories, while an
    // end word is still fetching its flags, and while a result waits
    assign item_stall = seq_stat.busy || end_pend_reg || (result_valid_reg && result_stall);
    assign item_acc   = item_valid && !item_stall;

    assign is_write = item_acc && (func == dwa_pkg::FUNC_WRITE);
    assign is_mark  = item_acc && (func == dwa_pkg::FUNC_MARK);
    assign is_live  = item_acc && (func == dwa_pkg::FUNC_LIVE);
    assign is_char  = item_acc && (func == dwa_pkg::FUNC_CHAR);
    assign is_end   = item_acc && (func == dwa_pkg::FUNC_END);

    assign from_ext = XW'(from_state);
    assign to_ext   = XW'(to_state);
    assign init_ext = XW'(initial_state_reg);
    assign wsym_ext = YW'(symbol_index);
    assign csym     = char_code - dwa_pkg::FIRST_CHAR;
    assign csym_ext = YW'(csym);

    assign from_ok = (from_ext < XW'(NUM_STATES));
    assign to_ok   = (to_ext < XW'(NUM_STATES));
    assign init_ok = (init_ext < XW'(NUM_STATES));
    assign wsym_ok = (wsym_ext < YW'(MAX_SYMBOLS));
    // bytes below 'a' and symbols past the alphabet in use or MAX_SYMBOLS lead to dead
    assign char_ok = (char_code >= dwa_pkg::FIRST_CHAR)
                  && (csym_ext < YW'(alphabet_size_reg))
                  && (csym_ext < YW'(MAX_SYMBOLS));

    //--------------------------------------------------------------------
    // run state
    //--------------------------------------------------------------------
    // a pending lookup resolves straight from the ram output, so the next
    // character can use the new state in the same cycle
    assign hit       = tbl_rdata[SW];
    assign res_state = (pend_reg && hit) ? tbl_rdata[SW-1:0] : run_state_reg;
    assign res_dead  = run_dead_reg || (pend_reg && !hit);

    always_comb
    begin
        run_state_next = res_state;
        run_dead_next  = res_dead;
        pend_next      = 1'b0;
        end_pend_next  = is_end;
        end_ok_next    = !res_dead;
        if (is_char && !res_dead)
        begin
            if (char_ok)
                pend_next = 1'b1;
            else
                run_dead_next = 1'b1;
        end
        if (is_end)
        begin
            // restart at the initial state, dead if that is out of range
            if (init_ok)
            begin
                run_state_next = init_ext[SW-1:0];
                run_dead_next  = 1'b0;
            end
            else
            begin
                run_state_next = '0;
                run_dead_next  = 1'b1;
            end
        end
    end

    //--------------------------------------------------------------------
    // result register
    //--------------------------------------------------------------------
    always_comb
    begin
        result_valid_next = result_valid_reg && result_stall;
        accepted_next     = accepted_reg;
        is_prefix_next    = is_prefix_reg;
        if (end_pend_reg)
        begin
            result_valid_next = 1'b1;
            accepted_next     = end_ok_reg && flg_rdata[dwa_pkg::FLAG_FINAL_BIT];
            is_prefix_next    = end_ok_reg && flg_rdata[dwa_pkg::FLAG_LIVE_BIT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_state_reg <= dwa_pkg::INITIAL_STATE_RST;
            alphabet_size_reg <= dwa_pkg::ALPHABET_SIZE_RST;
            run_state_reg     <= '0;
            run_dead_reg      <= 1'b0;
            pend_reg          <= 1'b0;
            end_pend_reg      <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            initial_state_reg <= initial_state_next;
            alphabet_size_reg <= alphabet_size_next;
            run_state_reg     <= run_state_next;
            run_dead_reg      <= run_dead_next;
            pend_reg          <= pend_next;
            end_pend_reg      <= end_pend_next;
            result_valid_reg  <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        end_ok_reg    <= end_ok_next;
        accepted_reg  <= accepted_next;
        is_prefix_reg <= is_prefix_next;
    end

    assign result_valid = result_valid_reg;
    assign accepted     = accepted_reg;
    assign is_prefix    = is_prefix_reg;

    //--------------------------------------------------------------------
    // memory port arbitration: the sequencer owns both rams while busy
    //--------------------------------------------------------------------
    always_comb
    begin
        if (seq_stat.busy)
        begin
            tbl_we    = seq_tbl_we;
            tbl_waddr = seq_tbl_waddr;
            tbl_wdata = seq_tbl_wdata;
            tbl_raddr = seq_tbl_raddr;
            flg_we    = seq_flg_we;
            flg_waddr = seq_flg_waddr;
            flg_wdata = seq_flg_wdata;
            flg_raddr = seq_flg_raddr;
        end
        else
        begin
            tbl_we    = is_write && from_ok && to_ok && wsym_ok;
            tbl_waddr = {from_ext[SW-1:0], wsym_ext[SYW-1:0]};
            tbl_wdata = {1'b1, to_ext[SW-1:0]};
            tbl_raddr = {res_state, csym_ext[SYW-1:0]};
            // marking final marks live as well
            flg_we    = is_mark && from_ok;
            flg_waddr = from_ext[SW-1:0];
            flg_wdata = '1;
            flg_raddr = res_state;
        end
    end

    assign seq_ctl.start         = is_live;
    assign seq_ctl.alphabet_size = alphabet_size_reg;

    //--------------------------------------------------------------------
    // storage and sequencer
    //--------------------------------------------------------------------
    dwa_ram #(
        .WIDTH (TW),
        .DEPTH (TDEPTH)
    ) u_next_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    dwa_ram #(
        .WIDTH (dwa_pkg::FLAG_W),
        .DEPTH (NUM_STATES)
    ) u_state_flags (
        .clk   (clk),
        .we    (flg_we),
        .waddr (flg_waddr),
        .wdata (flg_wdata),
        .raddr (flg_raddr),
        .rdata (flg_rdata)
    );

    dwa_live_seq #(
        .NUM_STATES  (NUM_STATES),
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_live_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (seq_ctl),
        .stat      (seq_stat),
        .tbl_rdata (tbl_rdata),
        .flg_rdata (flg_rdata),
        .tbl_we    (seq_tbl_we),
        .tbl_waddr (seq_tbl_waddr),
        .tbl_wdata (seq_tbl_wdata),
        .tbl_raddr (seq_tbl_raddr),
        .flg_we    (seq_flg_we),
        .flg_waddr (seq_flg_waddr),
        .flg_wdata (seq_flg_wdata),
        .flg_raddr (seq_flg_raddr)
    );

    //--------------------------------------------------------------------
    // assertions
    //--------------------------------------------------------------------
    // a final state is always live, so an accepted word is a prefix
    a_accept_implies_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (!accepted_reg || is_prefix_reg))
        else $error("accepted word not reported as prefix");

    // an end word delivers its result on the following edge
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        end_pend_reg |=> result_valid_reg)
        else $error("end word produced no result");

    // an accepted live computation request starts the sequencer, which then owns the memories
    a_live_starts: assert property (@(posedge clk) disable iff (!rst_n)
        is_live |=> seq_stat.busy)
        else $error("live computation did not start");

    // no run lookup or flag fetch is in flight while the sequencer owns the rams
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        seq_stat.busy |-> (!pend_reg && !end_pend_reg))
        else $error("run access overlaps sequencer");

endmodule

[src/dwa_ram.sv]
// dwa_ram: generic single-write, single-read synchronous ram, registered read
// no dependencies
`timescale 1ns / 1ps

module dwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/dwa_live_seq.sv]
// dwa_live_seq: clearing pass after reset and backward-reachability fixpoint
// over the transition and flag memories
// depends on dwa_pkg
`timescale 1ns / 1ps

module dwa_live_seq #(
    parameter int NUM_STATES  = dwa_pkg::NUM_STATES_DEF,
    parameter int MAX_SYMBOLS = dwa_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  dwa_pkg::seq_ctrl_t                      ctl,
    output dwa_pkg::seq_stat_t                      stat,
    input  logic [$clog2(NUM_STATES):0]             tbl_rdata,
    input  logic [dwa_pkg::FLAG_W-1:0]              flg_rdata,
    output logic                                    tbl_we,
    output logic [$clog2(NUM_STATES)+$clog2(MAX_SYMBOLS)-1:0] tbl_waddr,
    output logic [$clog2(NUM_STATES):0]             tbl_wdata,
    output logic [$clog2(NUM_STATES)+$clog2(MAX_SYMBOLS)-1:0] tbl_raddr,
    output logic                                    flg_we,
    output logic [$clog2(NUM_STATES)-1:0]           flg_waddr,
    output logic [dwa_pkg::FLAG_W-1:0]              flg_wdata,
    output logic [$clog2(NUM_STATES)-1:0]           flg_raddr
);

    localparam int SW     = $clog2(NUM_STATES);
    localparam int SYW    = $clog2(MAX_SYMBOLS);
    localparam int TAW    = SW + SYW;
    localparam int TDEPTH = NUM_STATES * (1 << SYW);

    dwa_pkg::live_state_t state_reg, state_next;
    logic [SW-1:0]  s_reg, s_next;
    logic [SYW-1:0] a_reg, a_next;
    logic [TAW-1:0] clr_reg, clr_next;
    logic           changed_reg, changed_next;
    logic           fin_reg, fin_next;

    logic                     s_last;
    logic                     a_last;
    logic                     clr_last;
    logic                     alpha_zero;
    logic                     hit;
    logic                     tgt_live;
    logic [dwa_pkg::SYM_EXT_W-1:0] a_inc;

    assign s_last     = (s_reg == SW'(NUM_STATES - 1));
    assign clr_last   = (clr_reg == TAW'(TDEPTH - 1));
    assign a_inc      = dwa_pkg::SYM_EXT_W'(a_reg) + dwa_pkg::SYM_EXT_W'(1);
    assign a_last     = (a_inc >= dwa_pkg::SYM_EXT_W'(ctl.alphabet_size))
                     || (a_inc >= dwa_pkg::SYM_EXT_W'(MAX_SYMBOLS));
    assign alpha_zero = (ctl.alphabet_size == 6'd0);
    assign hit        = tbl_rdata[SW];
    assign tgt_live   = flg_rdata[dwa_pkg::FLAG_LIVE_BIT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dwa_pkg::LS_CLEAR;
            s_reg       <= '0;
            a_reg       <= '0;
            clr_reg     <= '0;
            changed_reg <= 1'b0;
            fin_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            s_reg       <= s_next;
            a_reg       <= a_next;
            clr_reg     <= clr_next;
            changed_reg <= changed_next;
            fin_reg     <= fin_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dwa_pkg::LS_CLEAR:
                state_next = clr_last ? dwa_pkg::LS_IDLE : dwa_pkg::LS_CLEAR;
            dwa_pkg::LS_IDLE:
                state_next = ctl.start ? dwa_pkg::LS_COPY_RD : dwa_pkg::LS_IDLE;
            dwa_pkg::LS_COPY_RD:
                state_next = dwa_pkg::LS_COPY_WR;
            dwa_pkg::LS_COPY_WR:
                state_next = s_last ? dwa_pkg::LS_SCAN_RD : dwa_pkg::LS_COPY_RD;
            dwa_pkg::LS_SCAN_RD:
                state_next = dwa_pkg::LS_SCAN_CHK;
            dwa_pkg::LS_SCAN_CHK:
                state_next = (tgt_live || alpha_zero) ? dwa_pkg::LS_NEXT
                                                      : dwa_pkg::LS_SYM_RD;
            dwa_pkg::LS_SYM_RD:
                state_next = dwa_pkg::LS_SYM_TGT;
            dwa_pkg::LS_SYM_TGT:
            begin
                if (hit)
                    state_next = dwa_pkg::LS_SYM_CHK;
                else
                    state_next = a_last ? dwa_pkg::LS_NEXT : dwa_pkg::LS_SYM_RD;
            end
            dwa_pkg::LS_SYM_CHK:
                state_next = (tgt_live || a_last) ? dwa_pkg::LS_NEXT
                                                  : dwa_pkg::LS_SYM_RD;
            dwa_pkg::LS_NEXT:
            begin
                if (s_last)
                    state_next = changed_reg ? dwa_pkg::LS_SCAN_RD : dwa_pkg::LS_IDLE;
                else
                    state_next = dwa_pkg::LS_SCAN_RD;
            end
            default:
                state_next = dwa_pkg::LS_IDLE;
        endcase
    end

    // counters and pass bookkeeping
    always_comb
    begin
        s_next       = s_reg;
        a_next       = a_reg;
        clr_next     = clr_reg;
        changed_next = changed_reg;
        fin_next     = fin_reg;
        case (state_reg)
            dwa_pkg::LS_CLEAR:
                clr_next = clr_reg + TAW'(1);
            dwa_pkg::LS_IDLE:
            begin
                if (ctl.start)
                begin
                    s_next       = '0;
                    changed_next = 1'b0;
                end
            end
            dwa_pkg::LS_COPY_WR:
                s_next = s_last ? '0 : s_reg + SW'(1);
            dwa_pkg::LS_SCAN_CHK:
            begin
                a_next   = '0;
                fin_next = flg_rdata[dwa_pkg::FLAG_FINAL_BIT];
            end
            dwa_pkg::LS_SYM_TGT:
            begin
                if (!hit && !a_last)
                    a_next = a_reg + SYW'(1);
            end
            dwa_pkg::LS_SYM_CHK:
            begin
                if (tgt_live)
                    changed_next = 1'b1;
                else if (!a_last)
                    a_next = a_reg + SYW'(1);
            end
            dwa_pkg::LS_NEXT:
            begin
                s_next = s_last ? '0 : s_reg + SW'(1);
                if (s_last)
                    changed_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // memory ports
    always_comb
    begin
        tbl_we    = 1'b0;
        tbl_waddr = clr_reg;
        tbl_wdata = '0;
        tbl_raddr = {s_reg, a_reg};
        flg_we    = 1'b0;
        flg_waddr = s_reg;
        flg_wdata = '0;
        flg_raddr = s_reg;
        case (state_reg)
            dwa_pkg::LS_CLEAR:
            begin
                tbl_we    = 1'b1;
                flg_we    = 1'b1;
                flg_waddr = clr_reg[TAW-1:SYW];
            end
            dwa_pkg::LS_COPY_WR:
            begin
                // live starts as a copy of final
                flg_we = 1'b1;
                flg_wdata[dwa_pkg::FLAG_FINAL_BIT] = flg_rdata[dwa_pkg::FLAG_FINAL_BIT];
                flg_wdata[dwa_pkg::FLAG_LIVE_BIT]  = flg_rdata[dwa_pkg::FLAG_FINAL_BIT];
            end
            dwa_pkg::LS_SYM_TGT:
                flg_raddr = tbl_rdata[SW-1:0];
            dwa_pkg::LS_SYM_CHK:
            begin
                if (tgt_live)
                begin
                    flg_we = 1'b1;
                    flg_wdata[dwa_pkg::FLAG_FINAL_BIT] = fin_reg;
                    flg_wdata[dwa_pkg::FLAG_LIVE_BIT]  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign stat.busy     = (state_reg != dwa_pkg::LS_IDLE);
    assign stat.clearing = (state_reg == dwa_pkg::LS_CLEAR);

endmodule
